### sv/sts_pkg.sv
// ============================================================================
// sts_pkg: shared types and constants for the Taylor series sine block
// Field widths, Q30 angle constants, controller states and the command and
// status records between the controller and the datapath.
// ============================================================================
package sts_pkg;

   // interface field widths
   localparam int ANGLE_W    = 32;
   localparam int SINE_W     = 32;
   localparam int TERMS_W    = 5;
   localparam int REM_W      = 32;
   localparam int TOL_W      = 30;
   localparam int LIMIT_W    = 5;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 30;

   // internal widths
   localparam int FRAC_W      = 30;              // Q30 fraction bits
   localparam int RED_W       = ANGLE_W + 4;     // angle times 16, signed
   localparam int X_W         = 30;              // reduced angle, below pi/4
   localparam int MAG_W       = 31;              // term magnitude, up to 2^30
   localparam int PROD_W      = MAG_W + X_W;     // magnitude times x squared
   localparam int SUM_W       = 34;              // signed running sum
   localparam int DIV_W       = 31;              // halved dividend
   localparam int DVS_W       = 13;              // divisor 2k(2k+-1)
   localparam int RECIP_SHIFT = DIV_W + DVS_W;   // reciprocal scale
   localparam int RECIP_W     = RECIP_SHIFT;
   localparam int RHALF_W     = RECIP_W / 2;
   localparam int PART_W      = DIV_W + RHALF_W;
   localparam int QFULL_W     = DIV_W + RECIP_W;

   // Q30 constants, rounded to nearest
   localparam logic signed [RED_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [RED_W-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [RED_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [RED_W-1:0] QTR_PI_Q30  = 36'sd843314857;
   localparam logic [MAG_W-1:0]        ONE_Q30     = 31'd1073741824;
   localparam logic [PROD_W-1:0]       RND_Q30     = 61'd536870912;
   localparam logic signed [SUM_W-1:0] SUM_ONE     = 34'sd1073741824;
   localparam logic signed [SUM_W-1:0] SUM_NEG_ONE = -34'sd1073741824;
   localparam logic signed [SINE_W-1:0] SINE_ONE    = 32'sd1073741824;
   localparam logic signed [SINE_W-1:0] SINE_NEG_ONE = -32'sd1073741824;

   // register reset values
   localparam logic [TOL_W-1:0]   TOL_RESET   = 30'd1024;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd8;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TOLERANCE,
      CSR_TERM_LIMIT
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRAP,
      ST_FOLD_PI,
      ST_FOLD_HALF,
      ST_FOLD_QTR,
      ST_SQUARE,
      ST_TEST,
      ST_RECIP,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic wrap;
      logic fold_pi;
      logic fold_half;
      logic fold_qtr;
      logic square;
      logic term;
      logic recip;
      logic update;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic more;
   } status_type;

endpackage

### sv/sts_ctrl.sv
// ============================================================================
// sts_ctrl: sequencer for the Taylor series sine block
// Steps the datapath through range reduction and the term loop, and owns the
// input ready and the result valid flag.
// ============================================================================
module sts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  sts_pkg::status_type status,
   output sts_pkg::cmd_type    cmd
);
   import sts_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_WRAP;
         end
         ST_WRAP: begin
            if (status.in_range) state_in = ST_FOLD_PI;
         end
         ST_FOLD_PI:   state_in = ST_FOLD_HALF;
         ST_FOLD_HALF: state_in = ST_FOLD_QTR;
         ST_FOLD_QTR:  state_in = ST_SQUARE;
         ST_SQUARE:    state_in = ST_TEST;
         ST_TEST: begin
            state_in = status.more ? ST_RECIP : ST_FINISH;
         end
         ST_RECIP:     state_in = ST_UPDATE;
         ST_UPDATE:    state_in = ST_TEST;
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_WRAP:      cmd.wrap      = 1'b1;
         ST_FOLD_PI:   cmd.fold_pi   = 1'b1;
         ST_FOLD_HALF: cmd.fold_half = 1'b1;
         ST_FOLD_QTR:  cmd.fold_qtr  = 1'b1;
         ST_SQUARE:    cmd.square    = 1'b1;
         ST_TEST:      cmd.term      = status.more;
         ST_RECIP:     cmd.recip     = 1'b1;
         ST_UPDATE:    cmd.update    = 1'b1;
         ST_FINISH:    cmd.out_load  = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // hold the result until its transfer
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/sts_datapath.sv
// ============================================================================
// sts_datapath: range reduction and series arithmetic
// Holds the configuration registers, the reduced angle, the running term and
// sum, the reciprocal divide stages and the result register.
// ============================================================================
module sts_datapath #(
   parameter int MAX_TERMS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [sts_pkg::CSR_ADDR_W-1:0]       csr_index,
   input  logic [sts_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic signed [sts_pkg::ANGLE_W-1:0]   req_angle,
   input  logic                                 req_mode,
   input  sts_pkg::cmd_type                     cmd,
   output sts_pkg::status_type                  status,
   output logic signed [sts_pkg::SINE_W-1:0]    rsp_sine_value,
   output logic [sts_pkg::TERMS_W-1:0]          rsp_terms_used,
   output logic signed [sts_pkg::REM_W-1:0]     rsp_remainder_term
);
   import sts_pkg::*;

   localparam int KW    = $clog2(MAX_TERMS + 2);
   localparam int CW    = (KW > LIMIT_W) ? KW : LIMIT_W;
   localparam int TAB_N = 2 ** KW;

   // divisor and reciprocal tables, indexed by term index k
   logic [DVS_W-1:0]   dsin_w [TAB_N];
   logic [DVS_W-1:0]   dcos_w [TAB_N];
   logic [RECIP_W-1:0] rsin_w [TAB_N];
   logic [RECIP_W-1:0] rcos_w [TAB_N];

   for (genvar i = 0; i < TAB_N; i++) begin : g_tab
      localparam int DS = 2 * i * (2 * i + 1);
      localparam int DC = 2 * i * (2 * i - 1);
      localparam longint unsigned DS_DIV = (DS == 0) ? 1 : DS;
      localparam longint unsigned DC_DIV = (DC == 0) ? 1 : DC;
      localparam longint unsigned RS = ((64'd1 << RECIP_SHIFT) + DS_DIV - 1) / DS_DIV;
      localparam longint unsigned RC = ((64'd1 << RECIP_SHIFT) + DC_DIV - 1) / DC_DIV;
      assign dsin_w[i] = DVS_W'(DS);
      assign dcos_w[i] = DVS_W'(DC);
      assign rsin_w[i] = RECIP_W'(RS);
      assign rcos_w[i] = RECIP_W'(RC);
   end

   logic [TOL_W-1:0]          tol_ff, tol_in;
   logic [LIMIT_W-1:0]        limit_ff, limit_in;
   logic                      mode_ff, mode_in;
   logic signed [RED_W-1:0]   red_ff, red_in;
   logic                      qneg_ff, qneg_in;
   logic                      cos_ff, cos_in;
   logic [X_W-1:0]            x2_ff, x2_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic                      tneg_ff, tneg_in;
   logic [KW-1:0]             k_ff, k_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [PART_W-1:0]         hi_ff, hi_in;
   logic [PART_W-1:0]         lo_ff, lo_in;
   logic signed [SINE_W-1:0]  sine_ff, sine_in;
   logic [TERMS_W-1:0]        terms_ff, terms_in;
   logic signed [REM_W-1:0]   rem_ff, rem_in;

   logic [2*X_W-1:0]          xx_w;
   logic [PROD_W-1:0]         sq_w;
   logic signed [SUM_W-1:0]   mag_s_w;
   logic signed [SUM_W-1:0]   term_w;
   logic [DVS_W-1:0]          d_w;
   logic [RECIP_W-1:0]        r_w;
   logic [DIV_W:0]            num_w;
   logic [QFULL_W-1:0]        full_w;
   logic [CW-1:0]             n_w;
   logic                      zero_w;
   logic signed [SUM_W-1:0]   signed_sum_w;
   logic signed [SUM_W-1:0]   sat_w;

   always_comb begin
      xx_w    = red_ff[X_W-1:0] * red_ff[X_W-1:0];
      sq_w    = {1'b0, xx_w} + RND_Q30;
      mag_s_w = $signed(SUM_W'(mag_ff));
      term_w  = tneg_ff ? -mag_s_w : mag_s_w;
      d_w     = cos_ff ? dcos_w[k_ff] : dsin_w[k_ff];
      r_w     = cos_ff ? rcos_w[k_ff] : rsin_w[k_ff];
      num_w   = prod_ff[PROD_W-1:FRAC_W-1] + (DIV_W+1)'(d_w);
      full_w  = {hi_ff, RHALF_W'(0)} + QFULL_W'(lo_ff);
      n_w     = (CW'(limit_ff) > CW'(MAX_TERMS)) ? CW'(MAX_TERMS) : CW'(limit_ff);
      zero_w  = mode_ff && (n_w == '0);

      signed_sum_w = qneg_ff ? -sum_ff : sum_ff;
      if (signed_sum_w > SUM_ONE) begin
         sat_w = SUM_ONE;
      end else if (signed_sum_w < SUM_NEG_ONE) begin
         sat_w = SUM_NEG_ONE;
      end else begin
         sat_w = signed_sum_w;
      end

      status.in_range = !red_ff[RED_W-1] && (red_ff < TWO_PI_Q30);
      if (mode_ff) begin
         status.more = CW'(k_ff) < n_w;
      end else begin
         status.more = (mag_ff >= MAG_W'(tol_ff)) && (k_ff <= KW'(MAX_TERMS));
      end
   end

   always_comb begin
      tol_in   = tol_ff;
      limit_in = limit_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_TOLERANCE:  tol_in   = csr_wdata[TOL_W-1:0];
            CSR_TERM_LIMIT: limit_in = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      red_in   = red_ff;
      qneg_in  = qneg_ff;
      cos_in   = cos_ff;
      x2_in    = x2_ff;
      mag_in   = mag_ff;
      tneg_in  = tneg_ff;
      k_in     = k_ff;
      sum_in   = sum_ff;
      prod_in  = prod_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      sine_in  = sine_ff;
      terms_in = terms_ff;
      rem_in   = rem_ff;

      if (cmd.load) begin
         mode_in = req_mode;
         red_in  = $signed({req_angle, 4'b0000});
         qneg_in = 1'b0;
         cos_in  = 1'b0;
      end
      if (cmd.wrap) begin
         if (red_ff[RED_W-1]) begin
            red_in = red_ff + TWO_PI_Q30;
         end else if (red_ff >= TWO_PI_Q30) begin
            red_in = red_ff - TWO_PI_Q30;
         end
      end
      if (cmd.fold_pi && (red_ff >= PI_Q30)) begin
         qneg_in = 1'b1;
         red_in  = red_ff - PI_Q30;
      end
      if (cmd.fold_half && (red_ff >= HALF_PI_Q30)) begin
         red_in = PI_Q30 - red_ff;
      end
      if (cmd.fold_qtr && (red_ff >= QTR_PI_Q30)) begin
         cos_in = 1'b1;
         red_in = HALF_PI_Q30 - red_ff;
      end
      if (cmd.square) begin
         x2_in   = sq_w[2*X_W-1:FRAC_W];
         mag_in  = cos_ff ? ONE_Q30 : MAG_W'(red_ff[X_W-1:0]);
         tneg_in = 1'b0;
         k_in    = KW'(1);
         sum_in  = '0;
      end
      if (cmd.term) begin
         sum_in  = sum_ff + term_w;
         prod_in = mag_ff * x2_ff;
      end
      if (cmd.recip) begin
         hi_in = num_w[DIV_W:1] * r_w[RECIP_W-1:RHALF_W];
         lo_in = num_w[DIV_W:1] * r_w[RHALF_W-1:0];
      end
      if (cmd.update) begin
         mag_in  = full_w[QFULL_W-1:RECIP_SHIFT];
         tneg_in = !tneg_ff;
         k_in    = k_ff + KW'(1);
      end
      if (cmd.out_load) begin
         sine_in  = SINE_W'(sat_w);
         terms_in = TERMS_W'(k_ff);
         rem_in   = zero_w ? '0 : REM_W'(term_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= TOL_RESET;
         limit_ff <= LIMIT_RESET;
      end else begin
         tol_ff   <= tol_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      red_ff   <= red_in;
      qneg_ff  <= qneg_in;
      cos_ff   <= cos_in;
      x2_ff    <= x2_in;
      mag_ff   <= mag_in;
      tneg_ff  <= tneg_in;
      k_ff     <= k_in;
      sum_ff   <= sum_in;
      prod_ff  <= prod_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      sine_ff  <= sine_in;
      terms_ff <= terms_in;
      rem_ff   <= rem_in;
   end

   assign rsp_sine_value     = sine_ff;
   assign rsp_terms_used     = terms_ff;
   assign rsp_remainder_term = rem_ff;

endmodule

### sv/sine_taylor_series.sv
// ============================================================================
// sine_taylor_series: fixed-point sine by Taylor series with octant reduction
// Takes a signed Q5.26 angle and a mode bit on the req_ channel and returns
// the Q1.30 sine, the final term index and the first unsummed term on rsp_.
//
// Usage: one item is in flight at a time; req_ready is high only while the
// block is idle. The csr_ port writes the tolerance (index 0) and the term
// limit (index 1); write them only while the block is idle.
// After the input transfer the angle takes W (0 to 6) 2*pi wrap steps, then
// the pi, pi/2 and pi/4 folds and the square; each of the T summed terms (up
// to MAX_TERMS) passes the test, reciprocal and update states on the shared
// multiply and reciprocal-multiply stages. The next item is taken in the
// cycle after the result loads.
// The result sits in an output register: a stalled receiver holds it, while
// the block accepts and processes the next item, stalling only at the final
// load until the held result transfers.
// Reset clears the sequencer and the valid flag and restores tolerance 1024
// and term limit 8.
// ============================================================================
module sine_taylor_series #(
   parameter int MAX_TERMS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [sts_pkg::ANGLE_W-1:0]   req_angle,
   input  logic                                 req_mode,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [sts_pkg::SINE_W-1:0]    rsp_sine_value,
   output logic [sts_pkg::TERMS_W-1:0]          rsp_terms_used,
   output logic signed [sts_pkg::REM_W-1:0]     rsp_remainder_term,
   input  logic                                 csr_write_en,
   input  logic [sts_pkg::CSR_ADDR_W-1:0]       csr_index,
   input  logic [sts_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import sts_pkg::*;

   cmd_type    cmd;
   status_type status;

   sts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sts_datapath #(
      .MAX_TERMS (MAX_TERMS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_angle          (req_angle),
      .req_mode           (req_mode),
      .cmd                (cmd),
      .status             (status),
      .rsp_sine_value     (rsp_sine_value),
      .rsp_terms_used     (rsp_terms_used),
      .rsp_remainder_term (rsp_remainder_term)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in flight");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid || rsp_ready)
      else $error("held result overwritten");

   a_sine_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sine_value <= SINE_ONE && rsp_sine_value >= SINE_NEG_ONE)
      else $error("sine outside unit range");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_remainder_term <= SINE_ONE && rsp_remainder_term >= SINE_NEG_ONE)
      else $error("remainder term outside unit range");

endmodule
